[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/i2cts_pkg.sv]
package i2cts_pkg;

    // Field widths
    localparam int OPCODE_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 7;
    localparam int STATUS_W  = 8;
    localparam int CMD_W     = 3;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_QUEUE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_START  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_STATUS = 2'd2;

    // Bus commands
    localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEND       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RELEASE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STOP_RESET = 3'd5;

    // Bus status codes (low three bits masked)
    localparam logic [STATUS_W-1:0] STATUS_MASK     = 8'hF8;
    localparam logic [STATUS_W-1:0] STS_BUS_ERROR   = 8'h00;
    localparam logic [STATUS_W-1:0] STS_START       = 8'h08;
    localparam logic [STATUS_W-1:0] STS_RESTART     = 8'h10;
    localparam logic [STATUS_W-1:0] STS_ADDR_ACK    = 8'h18;
    localparam logic [STATUS_W-1:0] STS_ADDR_NACK   = 8'h20;
    localparam logic [STATUS_W-1:0] STS_DATA_ACK    = 8'h28;
    localparam logic [STATUS_W-1:0] STS_DATA_NACK   = 8'h30;
    localparam logic [STATUS_W-1:0] STS_ARB_LOST    = 8'h38;
    localparam logic [STATUS_W-1:0] STS_RX_ADDR_NACK = 8'h48;

    // One request item
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BYTE_W-1:0]   payload_byte;
        logic [ADDR_W-1:0]   target_address;
        logic [STATUS_W-1:0] bus_status;
    } item_t;

endpackage

[hw/rtl/i2cts_req_if.sv]
interface i2cts_req_if;
    logic                                valid;
    logic                                ready;
    logic [i2cts_pkg::OPCODE_W-1:0]      opcode;
    logic [i2cts_pkg::BYTE_W-1:0]        payload_byte;
    logic [i2cts_pkg::ADDR_W-1:0]        target_address;
    logic [i2cts_pkg::STATUS_W-1:0]      bus_status;

    modport source (output valid, opcode, payload_byte, target_address, bus_status,
                    input ready);
    modport sink   (input valid, opcode, payload_byte, target_address, bus_status,
                    output ready);
endinterface

[hw/rtl/i2cts_rsp_if.sv]
interface i2cts_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [i2cts_pkg::CMD_W-1:0]     bus_command;
    logic [i2cts_pkg::BYTE_W-1:0]    byte_out;
    logic                            accepted;
    logic                            busy_out;

    modport source (output valid, bus_command, byte_out, accepted, busy_out,
                    input ready);
    modport sink   (input valid, bus_command, byte_out, accepted, busy_out,
                    output ready);
endinterface

[hw/rtl/i2cts_ram.sv]
module i2cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port (read returns old data on collision)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/i2c_master_tx_sequencer.sv]
// Stages: input register, one decode/FIFO step, result register.
// Throughput: one item per cycle while the response side is not stalled.
// The FIFO head byte comes from a registered RAM read addressed with the next head pointer.
// Reset (rst_n, async, active low) empties the FIFO pointers and clears busy and the
// stored address byte; FIFO contents stay undefined until written, with no clearing pass.
`include "assert_macros.svh"

module i2c_master_tx_sequencer #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    i2cts_req_if.sink   req,
    i2cts_rsp_if.source rsp
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    // Input stage
    logic                 in_valid_reg;
    i2cts_pkg::item_t     item_reg;

    // Sequencer state
    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [i2cts_pkg::BYTE_W-1:0] addr_byte_reg, addr_byte_next;
    logic                 busy_reg, busy_next;

    // Read bypass for a head entry written in the previous cycle
    logic                 byp_hit_reg, byp_hit_next;
    logic [i2cts_pkg::BYTE_W-1:0] byp_data_reg;

    // Result stage
    logic                 out_valid_reg;
    logic [i2cts_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [i2cts_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                 acc_reg, acc_next;
    logic                 busy_out_reg;

    logic                 process;
    logic                 wr_en;
    logic [i2cts_pkg::BYTE_W-1:0] ram_rd_data;
    logic [i2cts_pkg::BYTE_W-1:0] head_data;
    logic [i2cts_pkg::STATUS_W-1:0] status_m;

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
        next_idx = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    // Handshake
    assign process   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || process;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            item_reg.opcode         <= req.opcode;
            item_reg.payload_byte   <= req.payload_byte;
            item_reg.target_address <= req.target_address;
            item_reg.bus_status     <= req.bus_status;
        end
    end

    // Transmit FIFO storage
    i2cts_ram #(
        .WIDTH (i2cts_pkg::BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (item_reg.payload_byte),
        .rd_addr (head_next),
        .rd_data (ram_rd_data)
    );

    assign head_data = byp_hit_reg ? byp_data_reg : ram_rd_data;
    assign status_m  = item_reg.bus_status & i2cts_pkg::STATUS_MASK;

    // Decode and state update for the item in the input register
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        addr_byte_next = addr_byte_reg;
        busy_next      = busy_reg;
        cmd_next       = i2cts_pkg::CMD_NONE;
        byte_next      = '0;
        acc_next       = 1'b0;
        wr_en          = 1'b0;
        if (process)
        begin
            unique case (item_reg.opcode)
                i2cts_pkg::OP_QUEUE:
                begin
                    if (!busy_reg && (count_reg != FULL_CNT))
                    begin
                        wr_en      = 1'b1;
                        tail_next  = next_idx(tail_reg);
                        count_next = count_reg + 1'b1;
                        acc_next   = 1'b1;
                    end
                end
                i2cts_pkg::OP_START:
                begin
                    if (!busy_reg)
                    begin
                        addr_byte_next = {item_reg.target_address, 1'b0};
                        busy_next      = 1'b1;
                        cmd_next       = i2cts_pkg::CMD_START;
                        acc_next       = 1'b1;
                    end
                end
                i2cts_pkg::OP_STATUS:
                begin
                    unique case (status_m) inside
                        i2cts_pkg::STS_START, i2cts_pkg::STS_RESTART:
                        begin
                            cmd_next  = i2cts_pkg::CMD_SEND;
                            byte_next = addr_byte_reg;
                        end
                        i2cts_pkg::STS_ADDR_ACK, i2cts_pkg::STS_DATA_ACK:
                        begin
                            if (count_reg == '0)
                            begin
                                cmd_next  = i2cts_pkg::CMD_STOP;
                                busy_next = 1'b0;
                            end
                            else
                            begin
                                cmd_next   = i2cts_pkg::CMD_SEND;
                                byte_next  = head_data;
                                head_next  = next_idx(head_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        i2cts_pkg::STS_ADDR_NACK, i2cts_pkg::STS_DATA_NACK,
                        i2cts_pkg::STS_RX_ADDR_NACK:
                        begin
                            cmd_next  = i2cts_pkg::CMD_STOP;
                            busy_next = 1'b0;
                        end
                        i2cts_pkg::STS_ARB_LOST:
                        begin
                            cmd_next  = i2cts_pkg::CMD_RELEASE;
                            busy_next = 1'b0;
                        end
                        i2cts_pkg::STS_BUS_ERROR:
                        begin
                            cmd_next  = i2cts_pkg::CMD_STOP_RESET;
                            busy_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    assign byp_hit_next = wr_en && (tail_reg == head_next);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            addr_byte_reg <= '0;
            busy_reg      <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            addr_byte_reg <= addr_byte_next;
            busy_reg      <= busy_next;
            byp_hit_reg   <= byp_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= item_reg.payload_byte;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            cmd_reg      <= cmd_next;
            byte_reg     <= byte_next;
            acc_reg      <= acc_next;
            busy_out_reg <= busy_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.bus_command = cmd_reg;
    assign rsp.byte_out    = byte_reg;
    assign rsp.accepted    = acc_reg;
    assign rsp.busy_out    = busy_out_reg;

    // Checks
    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    `ASSERT_IMPLIES(a_empty_ptrs, clk, rst_n, count_reg == '0, head_reg == tail_reg)
    `ASSERT_IMPLIES(a_start_busy, clk, rst_n, out_valid_reg && (cmd_reg == i2cts_pkg::CMD_START), busy_out_reg && acc_reg)
    `ASSERT_NEXT(a_stop_idle, clk, rst_n, process && (cmd_next == i2cts_pkg::CMD_STOP), !busy_reg)

endmodule
